// File: rtl/esbc_pkg.sv
// Shared types, constants and helper functions for the epoch-seconds to BCD calendar core.
// Used by every module under rtl; depends on nothing.

package esbc_pkg;

	localparam int unsigned NUM_STAGES = 8;

	typedef logic [NUM_STAGES:1] stage_en_t;

	// Counts for 2000-01-01 00:00:00 and 2100-01-01 00:00:00.
	localparam logic [31:0] EPOCH_LO = 32'd946684800;
	localparam logic [31:0] EPOCH_HI = 32'd4102444800;

	// Day split: seconds / 86400 = (seconds >> 7) / 675.
	localparam logic [25:0] DAY_RECIP       = 26'd50903317;
	localparam int unsigned DAY_RECIP_SHIFT = 35;
	localparam logic [9:0]  DAY_SECS_DIV128 = 10'd675;

	// Day number of 1996-03-01, start of the four-year cycle used below.
	localparam logic [15:0] DAY_BASE = 16'd9556;

	localparam logic [16:0] CYCLE_RECIP       = 17'd91868;
	localparam int unsigned CYCLE_RECIP_SHIFT = 27;
	localparam logic [15:0] DAYS_PER_CYCLE    = 16'd1461;
	localparam logic [10:0] DAYS_PER_YEAR     = 11'd365;

	// Hour split: x / 3600 = (x >> 4) / 225; minute split: r / 60 = (r >> 2) / 15.
	localparam logic [13:0] HOUR_RECIP       = 14'd9321;
	localparam int unsigned HOUR_RECIP_SHIFT = 21;
	localparam logic [16:0] HOUR_SECS        = 17'd3600;
	localparam logic [10:0] MIN_RECIP        = 11'd1093;
	localparam int unsigned MIN_RECIP_SHIFT  = 14;
	localparam logic [11:0] MIN_SECS         = 12'd60;

	// First day of each month within a year that starts on 1 March.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] start;
		unique case (mp)
			4'd0: start = 9'd0;
			4'd1: start = 9'd31;
			4'd2: start = 9'd61;
			4'd3: start = 9'd92;
			4'd4: start = 9'd122;
			4'd5: start = 9'd153;
			4'd6: start = 9'd184;
			4'd7: start = 9'd214;
			4'd8: start = 9'd245;
			4'd9: start = 9'd275;
			4'd10: start = 9'd306;
			4'd11: start = 9'd337;
			default: start = 9'd0;
		endcase
		return start;
	endfunction

	// Two packed BCD digits of a value below one hundred.
	function automatic logic [7:0] bcd2(input logic [6:0] v);
		logic [17:0] p;
		logic [3:0]  tens;
		logic [6:0]  units;
		p     = 18'(v) * 18'd205;
		tens  = p[14:11];
		units = v - 7'(tens) * 7'd10;
		return {tens, units[3:0]};
	endfunction

endpackage

// File: rtl/esbc_split.sv
// Stages one to three: splits the second count into a day number and the seconds of the day.
// Depends on esbc_pkg.

module esbc_split (
	input  logic                clk,
	input  esbc_pkg::stage_en_t adv,
	input  logic [31:0]         epoch_seconds,
	output logic [16:0]         day_secs_s3,
	output logic [15:0]         cycle_day_s3
);

	logic [50:0] day_prod;
	logic [15:0] days_s1;
	logic [24:0] n_s1;
	logic [6:0]  lo_s1;
	logic [25:0] back_prod;
	logic [15:0] days_s2;
	logic [24:0] n_s2;
	logic [24:0] prod_s2;
	logic [6:0]  lo_s2;
	logic [24:0] rem;

	assign day_prod = 51'(epoch_seconds[31:7]) * 51'(esbc_pkg::DAY_RECIP);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			days_s1 <= day_prod[esbc_pkg::DAY_RECIP_SHIFT +: 16];
			n_s1    <= epoch_seconds[31:7];
			lo_s1   <= epoch_seconds[6:0];
		end
	end

	assign back_prod = 26'(days_s1) * 26'(esbc_pkg::DAY_SECS_DIV128);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			prod_s2 <= back_prod[24:0];
			days_s2 <= days_s1;
			n_s2    <= n_s1;
			lo_s2   <= lo_s1;
		end
	end

	assign rem = n_s2 - prod_s2;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			day_secs_s3  <= {rem[9:0], lo_s2};
			cycle_day_s3 <= days_s2 - esbc_pkg::DAY_BASE;
		end
	end

endmodule

// File: rtl/esbc_hms.sv
// Stages four to seven of the time path: hour, minute and second from the seconds of the day.
// Depends on esbc_pkg.

module esbc_hms (
	input  logic                clk,
	input  esbc_pkg::stage_en_t adv,
	input  logic [16:0]         day_secs_s3,
	output logic [4:0]          hour_s7,
	output logic [5:0]          minute_s7,
	output logic [5:0]          second_s7
);

	logic [26:0] hour_prod;
	logic [4:0]  hour_s4;
	logic [16:0] secs_s4;
	logic [16:0] hour_back;
	logic [16:0] hour_rem;
	logic [4:0]  hour_s5;
	logic [11:0] rem_s5;
	logic [20:0] min_prod;
	logic [4:0]  hour_s6;
	logic [11:0] rem_s6;
	logic [5:0]  minute_s6;
	logic [11:0] min_back;
	logic [11:0] sec_rem;

	assign hour_prod = 27'(day_secs_s3[16:4]) * 27'(esbc_pkg::HOUR_RECIP);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			hour_s4 <= hour_prod[esbc_pkg::HOUR_RECIP_SHIFT +: 5];
			secs_s4 <= day_secs_s3;
		end
	end

	assign hour_back = 17'(hour_s4) * esbc_pkg::HOUR_SECS;
	assign hour_rem  = secs_s4 - hour_back;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			hour_s5 <= hour_s4;
			rem_s5  <= hour_rem[11:0];
		end
	end

	assign min_prod = 21'(rem_s5[11:2]) * 21'(esbc_pkg::MIN_RECIP);

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			hour_s6   <= hour_s5;
			rem_s6    <= rem_s5;
			minute_s6 <= min_prod[esbc_pkg::MIN_RECIP_SHIFT +: 6];
		end
	end

	assign min_back = 12'(minute_s6) * esbc_pkg::MIN_SECS;
	assign sec_rem  = rem_s6 - min_back;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			hour_s7   <= hour_s6;
			minute_s7 <= minute_s6;
			second_s7 <= sec_rem[5:0];
		end
	end

endmodule

// File: rtl/esbc_date.sv
// Stages four to seven of the date path: year, month and day from the day count since 1996-03-01.
// Depends on esbc_pkg.

module esbc_date (
	input  logic                clk,
	input  esbc_pkg::stage_en_t adv,
	input  logic [15:0]         cycle_day_s3,
	output logic [6:0]          year_s7,
	output logic [3:0]          month_s7,
	output logic [4:0]          day_s7
);

	logic [32:0] cycle_prod;
	logic [4:0]  cycle_s4;
	logic [15:0] nd_s4;
	logic [15:0] cycle_back;
	logic [15:0] cycle_rem;
	logic [4:0]  cycle_s5;
	logic [10:0] r_s5;
	logic [1:0]  yic;
	logic [10:0] doy_full;
	logic [4:0]  cycle_s6;
	logic [1:0]  yic_s6;
	logic [8:0]  doy_s6;
	logic [3:0]  mp;
	logic [8:0]  dom;
	logic [3:0]  month;
	logic [7:0]  year;

	assign cycle_prod = 33'(cycle_day_s3) * 33'(esbc_pkg::CYCLE_RECIP);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			cycle_s4 <= cycle_prod[esbc_pkg::CYCLE_RECIP_SHIFT +: 5];
			nd_s4    <= cycle_day_s3;
		end
	end

	assign cycle_back = 16'(cycle_s4) * esbc_pkg::DAYS_PER_CYCLE;
	assign cycle_rem  = nd_s4 - cycle_back;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			cycle_s5 <= cycle_s4;
			r_s5     <= cycle_rem[10:0];
		end
	end

	always_comb begin
		priority if (r_s5 >= 11'd1095) begin
			yic = 2'd3;
		end else if (r_s5 >= 11'd730) begin
			yic = 2'd2;
		end else if (r_s5 >= 11'd365) begin
			yic = 2'd1;
		end else begin
			yic = 2'd0;
		end
		doy_full = r_s5 - 11'(yic) * esbc_pkg::DAYS_PER_YEAR;
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			cycle_s6 <= cycle_s5;
			yic_s6   <= yic;
			doy_s6   <= doy_full[8:0];
		end
	end

	always_comb begin
		mp = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s6 >= esbc_pkg::month_start(4'(k))) begin
				mp = mp + 4'd1;
			end
		end
		dom   = doy_s6 - esbc_pkg::month_start(mp) + 9'd1;
		month = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
		year  = {1'b0, cycle_s6, 2'b00} + 8'(yic_s6) + 8'(mp >= 4'd10) - 8'd4;
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			year_s7  <= year[6:0];
			month_s7 <= month;
			day_s7   <= dom[4:0];
		end
	end

endmodule

// File: rtl/epoch_seconds_to_bcd_calendar_core.sv
// Top level of the epoch-seconds to BCD calendar core: stage control, range check and BCD output.
// Depends on esbc_pkg, esbc_split, esbc_hms and esbc_date.
//
//   Channel  Handshake                   Payload
//   item     item_valid / item_ready     epoch_seconds
//   result   result_valid / result_ready year_bcd, month_bcd, day_bcd, hour_bcd,
//                                        minute_bcd, second_bcd, out_of_range
//
// A transaction accepted at one edge passes through the eight register stages before it shows as a
// valid result, and one transaction can enter in every cycle unless a result that waits to be taken
// stalls the full pipeline.
// Reset clears the stage valid bits only.
// Each stage holds while its successor is full and stalled, so empty stages still
// fill while a finished result waits to be taken.

module epoch_seconds_to_bcd_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] epoch_seconds,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  year_bcd,
	output logic [4:0]  month_bcd,
	output logic [5:0]  day_bcd,
	output logic [5:0]  hour_bcd,
	output logic [6:0]  minute_bcd,
	output logic [6:0]  second_bcd,
	output logic        out_of_range
);

	localparam int unsigned N = esbc_pkg::NUM_STAGES;

	esbc_pkg::stage_en_t adv;
	logic [N:1]          valid_q;
	logic [N-1:1]        oor_q;
	logic [16:0]         day_secs_s3;
	logic [15:0]         cycle_day_s3;
	logic [4:0]          hour_s7;
	logic [5:0]          minute_s7;
	logic [5:0]          second_s7;
	logic [6:0]          year_s7;
	logic [3:0]          month_s7;
	logic [4:0]          day_s7;
	logic [7:0]          year_s8;
	logic [4:0]          month_s8;
	logic [5:0]          day_s8;
	logic [5:0]          hour_s8;
	logic [6:0]          minute_s8;
	logic [6:0]          second_s8;
	logic                oor_s8;
	logic [7:0]          year_b;
	logic [7:0]          month_b;
	logic [7:0]          day_b;
	logic [7:0]          hour_b;
	logic [7:0]          minute_b;
	logic [7:0]          second_b;

	always_comb begin
		adv[N] = result_ready | ~valid_q[N];
		for (int k = N - 1; k >= 1; k--) begin
			adv[k] = adv[k + 1] | ~valid_q[k];
		end
	end

	assign item_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) begin
				valid_q[1] <= item_valid;
			end
			for (int k = 2; k <= N; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			oor_q[1] <= (epoch_seconds < esbc_pkg::EPOCH_LO) ||
				(epoch_seconds >= esbc_pkg::EPOCH_HI);
		end
		for (int k = 2; k <= N - 1; k++) begin
			if (adv[k]) begin
				oor_q[k] <= oor_q[k - 1];
			end
		end
	end

	esbc_split u_split (
		.clk           (clk),
		.adv           (adv),
		.epoch_seconds (epoch_seconds),
		.day_secs_s3   (day_secs_s3),
		.cycle_day_s3  (cycle_day_s3)
	);

	esbc_hms u_hms (
		.clk         (clk),
		.adv         (adv),
		.day_secs_s3 (day_secs_s3),
		.hour_s7     (hour_s7),
		.minute_s7   (minute_s7),
		.second_s7   (second_s7)
	);

	esbc_date u_date (
		.clk          (clk),
		.adv          (adv),
		.cycle_day_s3 (cycle_day_s3),
		.year_s7      (year_s7),
		.month_s7     (month_s7),
		.day_s7       (day_s7)
	);

	assign year_b   = esbc_pkg::bcd2(year_s7);
	assign month_b  = esbc_pkg::bcd2(7'(month_s7));
	assign day_b    = esbc_pkg::bcd2(7'(day_s7));
	assign hour_b   = esbc_pkg::bcd2(7'(hour_s7));
	assign minute_b = esbc_pkg::bcd2(7'(minute_s7));
	assign second_b = esbc_pkg::bcd2(7'(second_s7));

	always_ff @(posedge clk) begin
		if (adv[N]) begin
			oor_s8 <= oor_q[N - 1];
			if (oor_q[N - 1]) begin
				year_s8   <= '0;
				month_s8  <= '0;
				day_s8    <= '0;
				hour_s8   <= '0;
				minute_s8 <= '0;
				second_s8 <= '0;
			end else begin
				year_s8   <= year_b;
				month_s8  <= month_b[4:0];
				day_s8    <= day_b[5:0];
				hour_s8   <= hour_b[5:0];
				minute_s8 <= minute_b[6:0];
				second_s8 <= second_b[6:0];
			end
		end
	end

	assign result_valid = valid_q[N];
	assign year_bcd     = year_s8;
	assign month_bcd    = month_s8;
	assign day_bcd      = day_s8;
	assign hour_bcd     = hour_s8;
	assign minute_bcd   = minute_s8;
	assign second_bcd   = second_s8;
	assign out_of_range = oor_s8;

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_of_range |-> year_bcd == 8'd0 && month_bcd == 5'd0 &&
			day_bcd == 6'd0 && hour_bcd == 6'd0 && minute_bcd == 7'd0 &&
			second_bcd == 7'd0)
		else $error("out-of-range result carries non-zero fields");

	a_date_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_of_range |-> month_bcd != 5'd0 && day_bcd != 6'd0)
		else $error("in-range result has a zero month or day");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> valid_q[1])
		else $error("accepted transaction did not reach the first stage");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> &valid_q)
		else $error("input blocked while a stage is empty");
`endif

endmodule
